/* rtl/core/bmm_pkg.sv */
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants for the blocked matrix multiply engine.
// ----------------------------------------------------------------------------
package bmm_pkg;

  localparam int DEF_MATRIX_DIM = 16;
  localparam int DEF_TILE_DIM   = 4;

  localparam int ELEM_W = 16;  // A and B element width
  localparam int PROD_W = 36;  // C element width
  localparam int IDX_W  = 4;   // row / col field width

  typedef enum logic [1:0] {
    KIND_WR_A    = 2'd0,
    KIND_WR_B    = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_RD_C    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_WRITE_OK = 2'd0,
    ST_DONE     = 2'd1,
    ST_READ     = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                    kind;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
  } bmm_in_t;

  typedef struct packed {
    status_t                  status;
    logic signed [PROD_W-1:0] product;
  } bmm_out_t;

  // Flags that travel with each multiply-accumulate step.
  typedef struct packed {
    logic valid;      // step carries a real operand pair
    logic first;      // first k of a C element
    logic last;       // last k of a C element
    logic last_elem;  // last C element of the product
  } mac_ctl_t;

endpackage

/* rtl/core/blocked_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// blocked_matrix_multiply
// Square matrix product engine with A, B and C element stores.
// ----------------------------------------------------------------------------
// Every input word gives one result word. Element writes of A or B answer in
// the cycle after acceptance; a C read answers from the S_READ state, after
// the registered C memory read. A compute word forms C = A * B through one
// shared multiply-accumulate unit fed by one read per cycle from each operand
// memory; no word is accepted until its result. Column tiles of TILE_DIM are
// walked outermost and each C element is summed exactly over k, then
// saturated to 36 bits. C reads as zero until the first product finishes;
// there is no clearing pass after reset. A and B hold garbage until written.
module blocked_matrix_multiply #(
  parameter int MATRIX_DIM = bmm_pkg::DEF_MATRIX_DIM,
  parameter int TILE_DIM   = bmm_pkg::DEF_TILE_DIM
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bmm_pkg::bmm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bmm_pkg::bmm_out_t out_data
);
  import bmm_pkg::*;

  localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(MATRIX_DIM);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_COMPUTE = 3'b010,
    S_READ    = 3'b100
  } state_t;

  state_t state;
  logic   accept, in_bounds, c_filled, rd_ok, load_result;
  logic [ADDR_W-1:0] host_addr;

  logic signed [ELEM_W-1:0] a_mem [CELLS];
  logic signed [ELEM_W-1:0] b_mem [CELLS];
  logic signed [PROD_W-1:0] c_mem [CELLS];
  logic signed [ELEM_W-1:0] a_rdata, b_rdata;
  logic signed [PROD_W-1:0] c_rdata;

  logic [ADDR_W-1:0] seq_a_addr, seq_b_addr, seq_c_addr;
  mac_ctl_t          seq_ctl;
  logic              mac_we, mac_done;
  logic [ADDR_W-1:0] mac_addr;
  logic signed [PROD_W-1:0] mac_wdata;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign in_bounds = (32'(in_data.row) < MATRIX_DIM) && (32'(in_data.col) < MATRIX_DIM);
  assign host_addr = ADDR_W'(in_data.row) * DIM_A + ADDR_W'(in_data.col);

  // a result word is loaded this cycle
  assign load_result = (state == S_READ) || (state == S_COMPUTE && mac_done) ||
                       (state == S_IDLE && accept &&
                        (in_data.kind == KIND_WR_A || in_data.kind == KIND_WR_B));

  always_ff @(posedge clk) begin
    if (accept && in_bounds && in_data.kind == KIND_WR_A) begin
      a_mem[host_addr] <= in_data.value;
    end
    if (accept && in_bounds && in_data.kind == KIND_WR_B) begin
      b_mem[host_addr] <= in_data.value;
    end
    a_rdata <= a_mem[seq_a_addr];
    b_rdata <= b_mem[seq_b_addr];
  end

  always_ff @(posedge clk) begin
    if (mac_we) begin
      c_mem[mac_addr] <= mac_wdata;
    end
    c_rdata <= c_mem[host_addr];
  end

  bmm_seq #(
    .MATRIX_DIM (MATRIX_DIM),
    .TILE_DIM   (TILE_DIM),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && in_data.kind == KIND_COMPUTE),
    .a_addr (seq_a_addr),
    .b_addr (seq_b_addr),
    .c_addr (seq_c_addr),
    .ctl    (seq_ctl)
  );

  bmm_mac #(
    .MATRIX_DIM (MATRIX_DIM),
    .ADDR_W     (ADDR_W)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (seq_ctl),
    .c_addr_in (seq_c_addr),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .c_we      (mac_we),
    .c_addr    (mac_addr),
    .c_wdata   (mac_wdata),
    .done      (mac_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      c_filled  <= 1'b0;
      rd_ok     <= 1'b0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.kind)
              KIND_WR_A, KIND_WR_B: begin
                out_data.status  <= ST_WRITE_OK;
                out_data.product <= '0;
              end
              KIND_COMPUTE: begin
                state <= S_COMPUTE;
              end
              KIND_RD_C: begin
                state <= S_READ;
                rd_ok <= in_bounds && c_filled;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          state            <= S_IDLE;
          out_data.status  <= ST_READ;
          out_data.product <= rd_ok ? c_rdata : '0;
        end
        S_COMPUTE: begin
          if (mac_done) begin
            state            <= S_IDLE;
            c_filled         <= 1'b1;
            out_data.status  <= ST_DONE;
            out_data.product <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_c_write_in_compute: assert property (@(posedge clk) disable iff (rst)
    mac_we |-> state == S_COMPUTE)
    else $error("C written outside a product");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_COMPUTE |-> !out_valid)
    else $error("result pending during a product");

  a_write_answers: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.kind == KIND_WR_A || in_data.kind == KIND_WR_B)
    |=> out_valid && out_data.status == ST_WRITE_OK)
    else $error("element write gave no answer");

  a_read_answers: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.kind == KIND_RD_C |-> ##2 out_valid && out_data.status == ST_READ)
    else $error("C read gave no answer");

endmodule

/* rtl/core/bmm_seq.sv */
// ----------------------------------------------------------------------------
// bmm_seq
// Loop sequencer for one product: walks column tiles, rows, columns within
// the tile and the inner index k, one operand pair per cycle.
// ----------------------------------------------------------------------------
module bmm_seq #(
  parameter int MATRIX_DIM = 16,
  parameter int TILE_DIM   = 4,
  parameter int ADDR_W     = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic [ADDR_W-1:0]  a_addr,
  output logic [ADDR_W-1:0]  b_addr,
  output logic [ADDR_W-1:0]  c_addr,
  output bmm_pkg::mac_ctl_t  ctl
);
  import bmm_pkg::*;

  localparam int CW = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
  localparam int TW = (TILE_DIM > 1) ? $clog2(TILE_DIM) : 1;
  localparam logic [CW-1:0]     LAST_IDX  = CW'(MATRIX_DIM - 1);
  localparam logic [TW-1:0]     LAST_OFS  = TW'(TILE_DIM - 1);
  localparam logic [ADDR_W-1:0] DIM_A     = ADDR_W'(MATRIX_DIM);

  logic          busy, busy_next;
  logic [CW-1:0] tile_base, tile_base_next;
  logic [CW-1:0] i_cnt, i_cnt_next;
  logic [CW-1:0] j_cnt, j_cnt_next;
  logic [TW-1:0] j_ofs, j_ofs_next;
  logic [CW-1:0] k_cnt, k_cnt_next;

  logic k_last, j_last, i_last, all_last;

  assign k_last   = (k_cnt == LAST_IDX);
  assign i_last   = (i_cnt == LAST_IDX);
  assign j_last   = (j_ofs == LAST_OFS) || (j_cnt == LAST_IDX);
  assign all_last = k_last && i_last && (j_cnt == LAST_IDX);

  always_comb begin
    busy_next      = busy;
    tile_base_next = tile_base;
    i_cnt_next     = i_cnt;
    j_cnt_next     = j_cnt;
    j_ofs_next     = j_ofs;
    k_cnt_next     = k_cnt;
    if (start) begin
      busy_next      = 1'b1;
      tile_base_next = '0;
      i_cnt_next     = '0;
      j_cnt_next     = '0;
      j_ofs_next     = '0;
      k_cnt_next     = '0;
    end else if (busy) begin
      if (!k_last) begin
        k_cnt_next = k_cnt + 1'b1;
      end else begin
        k_cnt_next = '0;
        if (!j_last) begin
          j_cnt_next = j_cnt + 1'b1;
          j_ofs_next = j_ofs + 1'b1;
        end else begin
          j_ofs_next = '0;
          if (!i_last) begin
            i_cnt_next = i_cnt + 1'b1;
            j_cnt_next = tile_base;
          end else begin
            // open the next column tile right after this one
            i_cnt_next     = '0;
            tile_base_next = j_cnt + 1'b1;
            j_cnt_next     = j_cnt + 1'b1;
            if (j_cnt == LAST_IDX) begin
              busy_next = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
    tile_base <= tile_base_next;
    i_cnt     <= i_cnt_next;
    j_cnt     <= j_cnt_next;
    j_ofs     <= j_ofs_next;
    k_cnt     <= k_cnt_next;
  end

  assign a_addr = ADDR_W'(i_cnt) * DIM_A + ADDR_W'(k_cnt);
  assign b_addr = ADDR_W'(k_cnt) * DIM_A + ADDR_W'(j_cnt);
  assign c_addr = ADDR_W'(i_cnt) * DIM_A + ADDR_W'(j_cnt);

  assign ctl.valid     = busy;
  assign ctl.first     = busy && (k_cnt == '0);
  assign ctl.last      = busy && k_last;
  assign ctl.last_elem = busy && all_last;

endmodule

/* rtl/core/bmm_mac.sv */
// ----------------------------------------------------------------------------
// bmm_mac
// Shared multiply-accumulate unit: registered 16x16 multiply, exact
// accumulate over k, and saturation of each finished C element.
// ----------------------------------------------------------------------------
module bmm_mac #(
  parameter int MATRIX_DIM = 16,
  parameter int ADDR_W     = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bmm_pkg::mac_ctl_t                  ctl_in,
  input  logic [ADDR_W-1:0]                  c_addr_in,
  input  logic signed [bmm_pkg::ELEM_W-1:0]  a_data,
  input  logic signed [bmm_pkg::ELEM_W-1:0]  b_data,
  output logic                               c_we,
  output logic [ADDR_W-1:0]                  c_addr,
  output logic signed [bmm_pkg::PROD_W-1:0]  c_wdata,
  output logic                               done
);
  import bmm_pkg::*;

  localparam int MUL_W  = 2 * ELEM_W;
  localparam int SUM_W  = MUL_W + $clog2(MATRIX_DIM);
  localparam int ACC_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - PROD_W + 1){1'b0}}, {(PROD_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W - PROD_W + 1){1'b1}}, {(PROD_W - 1){1'b0}}};

  mac_ctl_t                 ctl_rd, ctl_mul, ctl_acc;
  logic [ADDR_W-1:0]        addr_rd, addr_mul, addr_acc;
  logic signed [MUL_W-1:0]  prod;
  logic signed [ACC_W-1:0]  acc;

  // Stage 1 lines up with the operand memory read latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_rd  <= '0;
      ctl_mul <= '0;
      ctl_acc <= '0;
    end else begin
      ctl_rd  <= ctl_in;
      ctl_mul <= ctl_rd;
      ctl_acc <= ctl_mul;
    end
    addr_rd  <= c_addr_in;
    addr_mul <= addr_rd;
    addr_acc <= addr_mul;
    prod     <= a_data * b_data;
    if (ctl_mul.valid) begin
      acc <= ctl_mul.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  always_comb begin
    priority if (acc > SAT_HI) begin
      c_wdata = SAT_HI[PROD_W-1:0];
    end else if (acc < SAT_LO) begin
      c_wdata = SAT_LO[PROD_W-1:0];
    end else begin
      c_wdata = acc[PROD_W-1:0];
    end
  end

  assign c_we   = ctl_acc.valid && ctl_acc.last;
  assign c_addr = addr_acc;
  assign done   = ctl_acc.valid && ctl_acc.last_elem;

endmodule
